>>> hdl/aspa_pkg.sv
// ----------------------------------------------------------------------------
// aspa_pkg
// Shared widths and types for the aliquot sum / perfect / amicable block.
// ----------------------------------------------------------------------------
package aspa_pkg;

    localparam int NumW   = 32;
    localparam int SumW   = 36;
    localparam int CntW   = 12;
    localparam int DivW   = 17;
    localparam int AddrW  = 1;
    localparam logic [31:0] LimitReset = 32'd10000;

    // register byte addresses
    localparam logic [2:0] RegUpperLimit = 3'd0;

    // job handed from front to back
    typedef struct packed {
        logic [NumW-1:0] number;
        logic            below_two;
    } t_job;

    // result beat
    typedef struct packed {
        logic [SumW-1:0] divisor_sum;
        logic [CntW-1:0] divisor_count;
        logic            is_perfect;
        logic            is_amicable;
        logic [NumW-1:0] partner_value;
    } t_res;

endpackage

>>> hdl/aspa_if.sv
// ----------------------------------------------------------------------------
// aspa_in_if / aspa_out_if
// Valid/ready channels for number beats and result beats.
// ----------------------------------------------------------------------------
interface aspa_in_if;
    logic                       valid;
    logic                       ready;
    logic [aspa_pkg::NumW-1:0]  number_value;
    modport source (output valid, output number_value, input ready);
    modport sink   (input valid, input number_value, output ready);
endinterface

interface aspa_out_if;
    logic                       valid;
    logic                       ready;
    logic [aspa_pkg::SumW-1:0]  divisor_sum;
    logic [aspa_pkg::CntW-1:0]  divisor_count;
    logic                       is_perfect;
    logic                       is_amicable;
    logic [aspa_pkg::NumW-1:0]  partner_value;
    modport source (output valid, output divisor_sum, output divisor_count,
                    output is_perfect, output is_amicable, output partner_value,
                    input ready);
    modport sink   (input valid, input divisor_sum, input divisor_count,
                    input is_perfect, input is_amicable, input partner_value,
                    output ready);
endinterface

>>> hdl/aspa_front.sv
// ----------------------------------------------------------------------------
// aspa_front
// Accepts number beats, classifies small numbers and queues jobs (depth 2).
// ----------------------------------------------------------------------------
module aspa_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [aspa_pkg::NumW-1:0] i_number,
    output logic                 o_job_valid,
    input  logic                 i_job_take,
    output aspa_pkg::t_job       o_job
);
    aspa_pkg::t_job r_mem [2];
    logic [aspa_pkg::AddrW-1:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_mem[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_job_take && o_job_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp].number    <= i_number;
            r_mem[r_wp].below_two <= (i_number < aspa_pkg::NumW'(2));
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

>>> hdl/aspa_divsum.sv
// ----------------------------------------------------------------------------
// aspa_divsum
// Sum and count of proper divisors by trial division, one bit of the
// restoring divide per cycle.
// ----------------------------------------------------------------------------
module aspa_divsum (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [aspa_pkg::NumW-1:0]  i_n,
    output logic                       o_done,
    output logic [aspa_pkg::SumW-1:0]  o_sum,
    output logic [aspa_pkg::CntW-1:0]  o_cnt
);
    typedef enum logic [1:0] {S_IDLE, S_SQ, S_DIV, S_DONE} t_state;
    t_state r_state;
    logic [aspa_pkg::NumW-1:0] r_n, r_quo;
    logic [aspa_pkg::DivW-1:0] r_i;
    logic [aspa_pkg::NumW:0]   r_rem;
    logic [5:0]                r_bit;
    logic [aspa_pkg::SumW-1:0] r_sum;
    logic [aspa_pkg::CntW-1:0] r_cnt;
    logic [33:0]               r_sq;
    logic [aspa_pkg::NumW:0]   w_shift, w_diff;
    logic                      w_ge;

    assign w_shift = {r_rem[aspa_pkg::NumW-1:0], r_n[r_bit[4:0]]};
    assign w_diff  = w_shift - {16'd0, r_i};
    assign w_ge    = (w_shift >= {16'd0, r_i});
    assign o_done  = (r_state == S_DONE);
    assign o_sum   = r_sum;
    assign o_cnt   = r_cnt;

    // trial divisor loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_n;
                        r_i     <= aspa_pkg::DivW'(1);
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_sq    <= 34'd1;
                        r_state <= (i_n < aspa_pkg::NumW'(2)) ? S_DONE : S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_sq > {2'b0, r_n}) begin
                        r_state <= S_DONE;
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_bit   <= 6'd31;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_diff : w_shift;
                    r_quo <= {r_quo[aspa_pkg::NumW-2:0], w_ge};
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd0) begin
                        if ((w_ge ? w_diff : w_shift) == '0) begin
                            if (r_i != aspa_pkg::DivW'(1) && r_sq != {2'b0, r_n}) begin
                                r_sum <= r_sum + aspa_pkg::SumW'(r_i)
                                       + aspa_pkg::SumW'({r_quo[aspa_pkg::NumW-2:0], w_ge});
                                r_cnt <= r_cnt + aspa_pkg::CntW'(2);
                            end else begin
                                r_sum <= r_sum + aspa_pkg::SumW'(r_i);
                                r_cnt <= r_cnt + aspa_pkg::CntW'(1);
                            end
                        end
                        r_sq    <= r_sq + {16'd0, r_i, 1'b0} + 34'd1;
                        r_i     <= r_i + aspa_pkg::DivW'(1);
                        r_state <= S_SQ;
                    end
                end
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/aspa_back.sv
// ----------------------------------------------------------------------------
// aspa_back
// Runs the divisor sum for n, then for a partner in range; holds the result.
// ----------------------------------------------------------------------------
module aspa_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    output logic                       o_job_take,
    input  aspa_pkg::t_job             i_job,
    input  logic [31:0]                i_limit,
    output logic                       o_valid,
    input  logic                       i_ready,
    output aspa_pkg::t_res             o_res
);
    typedef enum logic [2:0] {S_IDLE, S_RUN1, S_CHK, S_RUN2, S_OUT} t_state;
    t_state r_state;
    logic [aspa_pkg::NumW-1:0] r_n;
    logic                      r_below_two;
    aspa_pkg::t_res            r_res;
    logic                      w_start, w_done, w_go2;
    logic [aspa_pkg::NumW-1:0] w_arg;
    logic [aspa_pkg::SumW-1:0] w_sum;
    logic [aspa_pkg::CntW-1:0] w_cnt;

    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign o_valid    = (r_state == S_OUT);
    assign o_res      = r_res;
    assign w_start    = o_job_take || (r_state == S_CHK && w_go2);
    assign w_arg      = (r_state == S_IDLE) ? i_job.number
                                            : r_res.divisor_sum[aspa_pkg::NumW-1:0];

    assign w_go2 = (r_res.divisor_sum > aspa_pkg::SumW'(r_n))
                && (r_res.divisor_sum <= aspa_pkg::SumW'(i_limit))
                && !r_below_two;

    aspa_divsum u_divsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_n     (w_arg),
        .o_done  (w_done),
        .o_sum   (w_sum),
        .o_cnt   (w_cnt)
    );

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_n         <= i_job.number;
                        r_below_two <= i_job.below_two;
                        r_state     <= S_RUN1;
                    end
                end
                S_RUN1: begin
                    if (w_done) begin
                        r_res.divisor_sum   <= w_sum;
                        r_res.divisor_count <= w_cnt;
                        r_res.is_perfect    <= (w_sum == aspa_pkg::SumW'(r_n)) && !r_below_two;
                        r_res.is_amicable   <= 1'b0;
                        r_res.partner_value <= '0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK:   r_state <= w_go2 ? S_RUN2 : S_OUT;
                S_RUN2: begin
                    if (w_done) begin
                        if (w_sum == aspa_pkg::SumW'(r_n)) begin
                            r_res.is_amicable   <= 1'b1;
                            r_res.partner_value <= r_res.divisor_sum[aspa_pkg::NumW-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT:   if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/aliquot_sum_perfect_amicable.sv
// ----------------------------------------------------------------------------
// aliquot_sum_perfect_amicable
// Proper divisor sum and count, perfect flag and amicable partner check.
// ----------------------------------------------------------------------------
// One number at a time is worked on. Each trial divisor i (i*i <= n) is tested
// in a bit-serial restoring divider; the partner is analysed the same way when
// the sum lies above n and within the upper limit. A two-entry queue in front
// lets up to two numbers wait while one is worked on; the result is held until
// taken.
module aliquot_sum_perfect_amicable (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aspa_in_if.sink     s_in,
    aspa_out_if.source  m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0]    r_limit;
    logic           w_job_valid, w_job_take;
    aspa_pkg::t_job w_job;
    aspa_pkg::t_res w_res;

    assign pready = 1'b1;
    assign prdata = (paddr == aspa_pkg::RegUpperLimit) ? r_limit : 32'd0;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= aspa_pkg::LimitReset;
        end else if (psel && penable && pwrite && paddr == aspa_pkg::RegUpperLimit) begin
            r_limit <= pwdata;
        end
    end

    aspa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_in.valid),
        .o_ready     (s_in.ready),
        .i_number    (s_in.number_value),
        .o_job_valid (w_job_valid),
        .i_job_take  (w_job_take),
        .o_job       (w_job)
    );

    aspa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_take  (w_job_take),
        .i_job       (w_job),
        .i_limit     (r_limit),
        .o_valid     (m_out.valid),
        .i_ready     (m_out.ready),
        .o_res       (w_res)
    );

    assign m_out.divisor_sum   = w_res.divisor_sum;
    assign m_out.divisor_count = w_res.divisor_count;
    assign m_out.is_perfect    = w_res.is_perfect;
    assign m_out.is_amicable   = w_res.is_amicable;
    assign m_out.partner_value = w_res.partner_value;
endmodule

>>> hdl/aspa_checker.sv
// ----------------------------------------------------------------------------
// aspa_checker
// Port-level checks on result beats.
// ----------------------------------------------------------------------------
module aspa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_is_perfect,
    input logic        o_is_amicable,
    input logic [31:0] o_partner_value,
    input logic [35:0] o_divisor_sum
);
    // a stalled result beat stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    // partner only with amicable flag
    a_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_amicable |-> o_partner_value == 32'd0)
        else $error("stray partner");
    // flags exclusive
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_perfect && o_is_amicable)) else $error("both flags");
    // amicable partner equals sum
    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_amicable |-> o_divisor_sum == {4'd0, o_partner_value})
        else $error("partner mismatch");
endmodule

bind aliquot_sum_perfect_amicable aspa_checker u_aspa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (m_out.valid),
    .i_ready         (m_out.ready),
    .o_is_perfect    (m_out.is_perfect),
    .o_is_amicable   (m_out.is_amicable),
    .o_partner_value (m_out.partner_value),
    .o_divisor_sum   (m_out.divisor_sum)
);
